// ===== src/dqec_pkg.sv =====
package dqec_pkg;

    localparam int DELTA_BITS_DEF = 16;
    localparam int TOTAL_BITS_DEF = 32;
    localparam int ODO_BITS       = 32;

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic right_b_level;
        logic right_a_level;
        logic left_b_level;
        logic left_a_level;
        logic right_b_edge;
        logic right_a_edge;
        logic left_b_edge;
        logic left_a_edge;
    } t_edge_word;

    localparam int IN_DATA_BITS = $bits(t_edge_word);

endpackage

// ===== src/dual_quadrature_encoder_counter.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: edge flags and pin levels; tuser: action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: deltas, totals, reverse flags, odometry
// cfg       in   i_cfg_we                       i_cfg_wdata: odometry_enable
//
// One word per cycle sustained while no tick stalls; a word is held in the input register and its
// update (two saturating steps per motor, then one add per total) is registered into the state
// and, for a tick, into the output register. Reset is synchronous and active low; it clears
// counts, totals, odometry and enable. An edge word never stalls; a tick stalls in the input
// register only while the output register holds a result that m_axis_tready has not taken.
module dual_quadrature_encoder_counter
    import dqec_pkg::*;
#(
    parameter int DELTA_BITS = DELTA_BITS_DEF,
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // left_a_edge, left_b_edge, right_a_edge, right_b_edge,
    // left_a_level, left_b_level, right_a_level, right_b_level
    input  logic [IN_DATA_BITS-1:0] s_axis_tdata,
    // action
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // left_change, right_change, left_total, right_total,
    // left_reverse, right_reverse, odometry_total, zero fill
    output logic [((2*DELTA_BITS+2*TOTAL_BITS+2+ODO_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int D         = DELTA_BITS;
    localparam int T         = TOTAL_BITS;
    localparam int OUT_BITS  = 2*D + 2*T + 2 + ODO_BITS;
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    function automatic logic [D-1:0] f_sat_step(input logic [D-1:0] v, input logic up);
        logic [D-1:0] hi;
        logic [D-1:0] lo;
        hi = {1'b0, {(D-1){1'b1}}};
        lo = {1'b1, {(D-1){1'b0}}};
        if (up) begin
            f_sat_step = (v == hi) ? hi : v + 1'b1;
        end else begin
            f_sat_step = (v == lo) ? lo : v - 1'b1;
        end
    endfunction

    function automatic logic [D-1:0] f_abs(input logic [D-1:0] v);
        f_abs = v[D-1] ? (~v + 1'b1) : v;
    endfunction

    logic                r_odo_en;
    logic                r_in_valid;
    t_edge_word          r_in_data;
    logic                r_in_action;
    logic                r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_data;

    logic [D-1:0]        r_left_pending;
    logic [D-1:0]        r_right_pending;
    logic [T-1:0]        r_left_total;
    logic [T-1:0]        r_right_total;
    logic                r_left_rev;
    logic                r_right_rev;
    logic [ODO_BITS-1:0] r_odo_total;

    logic                advance;
    logic                is_tick;
    logic [D-1:0]        left_step1;
    logic [D-1:0]        left_step2;
    logic [D-1:0]        right_step1;
    logic [D-1:0]        right_step2;
    logic [63:0]         left_ext;
    logic [63:0]         right_ext;
    logic [D:0]          abs_sum;
    logic [ODO_BITS-1:0] mean;

    logic [D-1:0]        n_left_pending;
    logic [D-1:0]        n_right_pending;
    logic [T-1:0]        n_left_total;
    logic [T-1:0]        n_right_total;
    logic                n_left_rev;
    logic                n_right_rev;
    logic [ODO_BITS-1:0] n_odo_total;
    logic [OUT_WIDTH-1:0] n_out_data;

    assign is_tick       = (r_in_action == ACT_TICK);
    assign advance       = r_in_valid && (!is_tick || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        left_step1  = r_in_data.left_a_edge
                    ? f_sat_step(r_left_pending, !r_in_data.left_b_level) : r_left_pending;
        left_step2  = r_in_data.left_b_edge
                    ? f_sat_step(left_step1, r_in_data.left_a_level) : left_step1;
        right_step1 = r_in_data.right_a_edge
                    ? f_sat_step(r_right_pending, r_in_data.right_b_level) : r_right_pending;
        right_step2 = r_in_data.right_b_edge
                    ? f_sat_step(right_step1, !r_in_data.right_a_level) : right_step1;

        left_ext  = {{(64-D){r_left_pending[D-1]}}, r_left_pending};
        right_ext = {{(64-D){r_right_pending[D-1]}}, r_right_pending};
        abs_sum   = {1'b0, f_abs(r_left_pending)} + {1'b0, f_abs(r_right_pending)};
        mean      = ODO_BITS'(abs_sum >> 1);

        n_left_pending  = r_left_pending;
        n_right_pending = r_right_pending;
        n_left_total    = r_left_total;
        n_right_total   = r_right_total;
        n_left_rev      = r_left_rev;
        n_right_rev     = r_right_rev;
        n_odo_total     = r_odo_total;

        unique case (r_in_action)
            ACT_EDGE: begin
                n_left_pending  = left_step2;
                n_right_pending = right_step2;
            end
            ACT_TICK: begin
                n_left_pending  = '0;
                n_right_pending = '0;
                n_left_total    = r_left_total + left_ext[T-1:0];
                n_right_total   = r_right_total + right_ext[T-1:0];
                n_left_rev      = r_left_pending[D-1];
                n_right_rev     = r_right_pending[D-1];
                if (r_odo_en) begin
                    n_odo_total = r_odo_total + mean;
                end
            end
            default: begin
            end
        endcase

        n_out_data               = '0;
        n_out_data[OUT_BITS-1:0] = {n_odo_total, n_right_rev, n_left_rev,
                                    n_right_total, n_left_total,
                                    r_right_pending, r_left_pending};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odo_en        <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_left_pending  <= '0;
            r_right_pending <= '0;
            r_left_total    <= '0;
            r_right_total   <= '0;
            r_left_rev      <= 1'b0;
            r_right_rev     <= 1'b0;
            r_odo_total     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_odo_en <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_left_pending  <= n_left_pending;
                r_right_pending <= n_right_pending;
                r_left_total    <= n_left_total;
                r_right_total   <= n_right_total;
                r_left_rev      <= n_left_rev;
                r_right_rev     <= n_right_rev;
                r_odo_total     <= n_odo_total;
            end
            if (advance && is_tick) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data   <= t_edge_word'(s_axis_tdata);
            r_in_action <= s_axis_tuser;
        end
        if (advance && is_tick) begin
            r_out_data <= n_out_data;
        end
    end

    a_result_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid && r_in_action == ACT_TICK))
        else $error("result appeared without a tick");

    a_tick_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_tick) |=> (r_left_pending == '0 && r_right_pending == '0))
        else $error("pending counts not cleared by tick");

    a_edge_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_action == ACT_EDGE) |-> s_axis_tready)
        else $error("edge word stalled");

endmodule
